// ===== sv/ired_pkg.sv =====
`default_nettype none
package ired_pkg;

    localparam int INTERVAL_WIDTH = 8;
    localparam int S_TDATA_WIDTH  = ((INTERVAL_WIDTH + 7) / 8) * 8;
    localparam int M_TDATA_WIDTH  = 24;
    localparam int CFG_IDX_WIDTH  = 8;
    localparam int CFG_DATA_WIDTH = 8;
    localparam int FRAME_EDGES    = 32;
    localparam int STORE_ADDR_W   = $clog2(FRAME_EDGES);
    localparam int EDGE_IDX_WIDTH = 6;
    localparam int BYTE_SEL_W     = 2;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        REG_ZERO_MIN     = 8'd0,
        REG_ZERO_MAX     = 8'd1,
        REG_ONE_MIN      = 8'd2,
        REG_ONE_MAX      = 8'd3,
        REG_LEAD_LIMIT   = 8'd4,
        REG_REPEAT_LIMIT = 8'd5
    } reg_index_t;

    localparam logic [7:0] RST_ZERO_MIN     = 8'd8;
    localparam logic [7:0] RST_ZERO_MAX     = 8'd14;
    localparam logic [7:0] RST_ONE_MIN      = 8'd18;
    localparam logic [7:0] RST_ONE_MAX      = 8'd26;
    localparam logic [7:0] RST_LEAD_LIMIT   = 8'd125;
    localparam logic [7:0] RST_REPEAT_LIMIT = 8'd105;

    localparam logic [7:0] BYTE_LOW_MASK = 8'h7f;
    localparam logic [7:0] BYTE_TOP_BIT  = 8'h80;
    localparam logic [7:0] BYTE_ALL_ONES = 8'hff;

    typedef struct packed {
        logic [7:0] zero_min;
        logic [7:0] zero_max;
        logic [7:0] one_min;
        logic [7:0] one_max;
        logic [7:0] lead_limit;
        logic [7:0] repeat_limit;
    } cfg_t;

endpackage
`default_nettype wire

// ===== sv/ired_ram.sv =====
`default_nettype none
module ired_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

// ===== sv/ired_cfg_regs.sv =====
`default_nettype none
module ired_cfg_regs
    import ired_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [CFG_IDX_WIDTH-1:0]  cfg_index,
    input  wire logic [CFG_DATA_WIDTH-1:0] cfg_data,
    output cfg_t                           cfg
);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.zero_min     <= RST_ZERO_MIN;
            cfg_reg.zero_max     <= RST_ZERO_MAX;
            cfg_reg.one_min      <= RST_ONE_MIN;
            cfg_reg.one_max      <= RST_ONE_MAX;
            cfg_reg.lead_limit   <= RST_LEAD_LIMIT;
            cfg_reg.repeat_limit <= RST_REPEAT_LIMIT;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_ZERO_MIN:     cfg_reg.zero_min     <= cfg_data;
                REG_ZERO_MAX:     cfg_reg.zero_max     <= cfg_data;
                REG_ONE_MIN:      cfg_reg.one_min      <= cfg_data;
                REG_ONE_MAX:      cfg_reg.one_max      <= cfg_data;
                REG_LEAD_LIMIT:   cfg_reg.lead_limit   <= cfg_data;
                REG_REPEAT_LIMIT: cfg_reg.repeat_limit <= cfg_data;
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== sv/ired_bit_unit.sv =====
`default_nettype none
module ired_bit_unit
    import ired_pkg::*;
(
    input  wire logic [INTERVAL_WIDTH-1:0] interval,
    input  wire cfg_t                      cfg,
    input  wire logic [7:0]                byte_in,
    output logic      [7:0]                byte_out
);

    logic is_zero;
    logic is_one;

    always_comb begin
        is_zero = (interval > INTERVAL_WIDTH'(cfg.zero_min)) &&
                  (interval < INTERVAL_WIDTH'(cfg.zero_max));
        is_one  = (interval > INTERVAL_WIDTH'(cfg.one_min)) &&
                  (interval < INTERVAL_WIDTH'(cfg.one_max));
        if (is_zero) begin
            byte_out = (byte_in >> 1) & BYTE_LOW_MASK;
        end else if (is_one) begin
            byte_out = (byte_in >> 1) | BYTE_TOP_BIT;
        end else begin
            byte_out = byte_in;
        end
    end

endmodule
`default_nettype wire

// ===== sv/ir_edge_interval_decoder_unit.sv =====
// Channel  Direction  Handshake            Payload
// s_       in         s_tvalid / s_tready  tdata: interval; tuser: timed_out
// m_       out        m_tvalid / m_tready  tdata: key, address_low, address_high;
//                                          tuser: code_ok
// cfg_     in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// An edge that does not complete a frame is accepted while s_tready stays high.
// The 32nd stored edge starts a decode, followed by any wait for the output
// register: one stored interval is read from the RAM and classed per cycle.
// s_tready is low during the decode. A result held on m_ blocks edges only while a finished decode waits for it.
// aresetn is synchronous: flags, edge index and frame bytes clear; config registers load their defaults.
`default_nettype none
module ir_edge_interval_decoder_unit
    import ired_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [S_TDATA_WIDTH-1:0]  s_tdata,  // interval
    input  wire logic                      s_tuser,  // timed_out
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic      [M_TDATA_WIDTH-1:0]  m_tdata,  // key, address_low, address_high
    output logic                           m_tuser,  // code_ok
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [CFG_IDX_WIDTH-1:0]  cfg_index,
    input  wire logic [CFG_DATA_WIDTH-1:0] cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_FINISH
    } state_t;

    cfg_t                        cfg;
    state_t                      state_reg, state_next;
    logic [EDGE_IDX_WIDTH-1:0]   edge_idx_reg, edge_idx_next;
    logic [EDGE_IDX_WIDTH-1:0]   edge_inc;
    logic                        lead_reg, lead_next;
    logic                        repeat_reg, repeat_next;
    logic [7:0]                  frame_reg [4];
    logic [7:0]                  frame_next [4];
    logic [STORE_ADDR_W:0]       cnt_reg, cnt_next;
    logic                        proc_valid_reg, proc_valid_next;
    logic [STORE_ADDR_W-1:0]     proc_pos_reg, proc_pos_next;
    logic                        m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_WIDTH-1:0]    m_tdata_reg, m_tdata_next;
    logic                        m_tuser_reg, m_tuser_next;
    logic [INTERVAL_WIDTH-1:0]   in_interval;
    logic                        in_accept;
    logic                        wr_en;
    logic [STORE_ADDR_W-1:0]     rd_addr;
    logic [INTERVAL_WIDTH-1:0]   rd_data;
    logic [BYTE_SEL_W-1:0]       byte_sel;
    logic [7:0]                  byte_shifted;
    logic [8:0]                  check_sum;
    logic                        ok;

    ired_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ired_ram #(
        .WIDTH (INTERVAL_WIDTH),
        .DEPTH (FRAME_EDGES)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (edge_idx_reg[STORE_ADDR_W-1:0]),
        .wr_data (in_interval),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign byte_sel = proc_pos_reg[STORE_ADDR_W-1 -: BYTE_SEL_W];

    ired_bit_unit u_bit (
        .interval (rd_data),
        .cfg      (cfg),
        .byte_in  (frame_reg[byte_sel]),
        .byte_out (byte_shifted)
    );

    assign in_interval = s_tdata[INTERVAL_WIDTH-1:0];
    assign s_tready    = (state_reg == ST_IDLE);
    assign in_accept   = s_tvalid && s_tready;
    assign wr_en       = in_accept && !s_tuser && (lead_reg || repeat_reg);
    assign edge_inc    = edge_idx_reg + EDGE_IDX_WIDTH'(1);
    assign rd_addr     = cnt_reg[STORE_ADDR_W-1:0];
    assign m_tvalid    = m_tvalid_reg;
    assign m_tdata     = m_tdata_reg;
    assign m_tuser     = m_tuser_reg;

    always_comb begin
        check_sum = {1'b0, frame_reg[2]} + {1'b0, frame_reg[3]};
        ok        = (check_sum == {1'b0, BYTE_ALL_ONES});
    end

    always_comb begin
        state_next      = state_reg;
        edge_idx_next   = edge_idx_reg;
        lead_next       = lead_reg;
        repeat_next     = repeat_reg;
        frame_next      = frame_reg;
        cnt_next        = cnt_reg;
        proc_valid_next = 1'b0;
        proc_pos_next   = proc_pos_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        if (proc_valid_reg) begin
            frame_next[byte_sel] = byte_shifted;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    if (s_tuser) begin
                        edge_idx_next = '0;
                        lead_next     = 1'b0;
                        repeat_next   = 1'b0;
                    end else begin
                        if (lead_reg || repeat_reg) begin
                            if (edge_inc >= EDGE_IDX_WIDTH'(FRAME_EDGES)) begin
                                edge_idx_next = '0;
                                lead_next     = 1'b0;
                                cnt_next      = '0;
                                state_next    = ST_DECODE;
                            end else begin
                                edge_idx_next = edge_inc;
                            end
                        end
                        if (in_interval > INTERVAL_WIDTH'(cfg.lead_limit)) begin
                            lead_next     = 1'b1;
                            edge_idx_next = '0;
                        end
                        if (in_interval > INTERVAL_WIDTH'(cfg.repeat_limit)) begin
                            repeat_next   = 1'b1;
                            edge_idx_next = '0;
                        end
                    end
                end
            end
            ST_DECODE: begin
                if (!cnt_reg[STORE_ADDR_W]) begin
                    proc_valid_next = 1'b1;
                    proc_pos_next   = cnt_reg[STORE_ADDR_W-1:0];
                    cnt_next        = cnt_reg + (STORE_ADDR_W+1)'(1);
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {frame_reg[1], frame_reg[0],
                                     ok ? frame_reg[2] : BYTE_ALL_ONES};
                    m_tuser_next  = ok;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            edge_idx_reg   <= '0;
            lead_reg       <= 1'b0;
            repeat_reg     <= 1'b0;
            frame_reg      <= '{default: '0};
            cnt_reg        <= '0;
            proc_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            edge_idx_reg   <= edge_idx_next;
            lead_reg       <= lead_next;
            repeat_reg     <= repeat_next;
            frame_reg      <= frame_next;
            cnt_reg        <= cnt_next;
            proc_valid_reg <= proc_valid_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
        proc_pos_reg <= proc_pos_next;
        m_tdata_reg  <= m_tdata_next;
        m_tuser_reg  <= m_tuser_next;
    end

endmodule
`default_nettype wire

// ===== dv/ir_edge_interval_decoder_unit_test.sv =====
`timescale 1ns / 100ps
module ir_edge_interval_decoder_unit_test;
    import ired_pkg::*;

    localparam int ITEM_TARGET    = 1950;
    localparam int RANDOM_FRAMES  = 24;
    localparam int SETTLE_CYCLES  = 48;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PRINT_CAP      = 100;

    typedef struct packed {
        logic [7:0] key;
        logic       code_ok;
        logic [7:0] addr_lo;
        logic [7:0] addr_hi;
    } ir_frame_t;

    logic aclk;
    logic aresetn = 1'b0;

    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [S_TDATA_WIDTH-1:0]  s_tdata  = '0;
    logic                      s_tuser  = 1'b0;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [M_TDATA_WIDTH-1:0]  m_tdata;
    logic                      m_tuser;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_IDX_WIDTH-1:0]  cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0] cfg_data  = '0;

    // receiver copy
    cfg_t                      model_cfg;
    logic [7:0]                ticks_mem [FRAME_EDGES];
    logic [7:0]                frame_reg [4];
    logic [EDGE_IDX_WIDTH-1:0] edge_count;
    logic                      lead_flag;
    logic                      repeat_flag;
    ir_frame_t                 pending_frames [$];

    bit gap_enable   = 1'b0;
    bit stall_enable = 1'b0;
    int edges_sent       = 0;
    int frames_predicted = 0;
    int frames_checked   = 0;
    int regs_written     = 0;
    int mismatches       = 0;
    int quiet_cycles     = 0;

    ir_edge_interval_decoder_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic cfg_t make_windows(input logic [7:0] zmin, zmax, omin, omax,
                                          input logic [7:0] lead, rep);
        cfg_t c;
        c.zero_min     = zmin;
        c.zero_max     = zmax;
        c.one_min      = omin;
        c.one_max      = omax;
        c.lead_limit   = lead;
        c.repeat_limit = rep;
        return c;
    endfunction

    function automatic void clear_receiver();
        model_cfg = make_windows(RST_ZERO_MIN, RST_ZERO_MAX, RST_ONE_MIN, RST_ONE_MAX,
                                 RST_LEAD_LIMIT, RST_REPEAT_LIMIT);
        foreach (frame_reg[b]) frame_reg[b] = '0;
        edge_count  = '0;
        lead_flag   = 1'b0;
        repeat_flag = 1'b0;
    endfunction

    function automatic void decode_bytes();
        logic [7:0] t;
        for (int b = 0; b < 4; b++) begin
            for (int k = 0; k < 8; k++) begin
                t = ticks_mem[b * 8 + k];
                if (t > model_cfg.zero_min && t < model_cfg.zero_max)
                    frame_reg[b] = {1'b0, frame_reg[b][7:1]};
                else if (t > model_cfg.one_min && t < model_cfg.one_max)
                    frame_reg[b] = {1'b1, frame_reg[b][7:1]};
            end
        end
    endfunction

    function automatic void advance_receiver(input logic [7:0] ticks, input logic tmo);
        ir_frame_t res;
        logic      ok;
        if (tmo) begin
            edge_count  = '0;
            lead_flag   = 1'b0;
            repeat_flag = 1'b0;
            return;
        end
        if (lead_flag || repeat_flag) begin
            ticks_mem[edge_count[STORE_ADDR_W-1:0]] = ticks;
            edge_count = edge_count + 1'b1;
            if (edge_count >= FRAME_EDGES) begin
                edge_count = '0;
                lead_flag  = 1'b0;
                decode_bytes();
                ok = ({1'b0, frame_reg[2]} + {1'b0, frame_reg[3]}) == {1'b0, BYTE_ALL_ONES};
                res.key     = ok ? frame_reg[2] : BYTE_ALL_ONES;
                res.code_ok = ok;
                res.addr_lo = frame_reg[0];
                res.addr_hi = frame_reg[1];
                pending_frames.push_back(res);
                frames_predicted++;
            end
        end
        if (ticks > model_cfg.lead_limit) begin
            lead_flag  = 1'b1;
            edge_count = '0;
        end
        if (ticks > model_cfg.repeat_limit) begin
            repeat_flag = 1'b1;
            edge_count  = '0;
        end
    endfunction

    function automatic logic [7:0] pick_ticks(input logic [7:0] lo, hi);
        if (int'(hi) > int'(lo) + 1)
            return 8'($urandom_range(int'(lo) + 1, int'(hi) - 1));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] lead_ticks();
        if (model_cfg.lead_limit == BYTE_ALL_ONES) return BYTE_ALL_ONES;
        return 8'($urandom_range(int'(model_cfg.lead_limit) + 1, 255));
    endfunction

    function automatic logic [7:0] repeat_ticks();
        if (model_cfg.repeat_limit < model_cfg.lead_limit)
            return 8'($urandom_range(int'(model_cfg.repeat_limit) + 1,
                                     int'(model_cfg.lead_limit)));
        return lead_ticks();
    endfunction

    function automatic logic [31:0] random_payload(input bit good);
        logic [7:0] lo, hi, cmd, inv;
        lo  = 8'($urandom);
        hi  = 8'($urandom);
        cmd = 8'($urandom);
        inv = 8'($urandom);
        if (good) inv = ~cmd;
        return {inv, cmd, hi, lo};
    endfunction

    function automatic cfg_t random_windows();
        cfg_t c;
        c.zero_min     = 8'($urandom_range(0, 20));
        c.zero_max     = 8'($urandom_range(int'(c.zero_min) + 2, int'(c.zero_min) + 30));
        c.one_min      = 8'($urandom_range(int'(c.zero_max), int'(c.zero_max) + 20));
        c.one_max      = 8'($urandom_range(int'(c.one_min) + 2, int'(c.one_min) + 40));
        c.repeat_limit = 8'($urandom_range(int'(c.one_max), 200));
        c.lead_limit   = 8'($urandom_range(int'(c.repeat_limit), 254));
        return c;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_CAP) $display("MISMATCH @%0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_frame_result();
        ir_frame_t want;
        if (pending_frames.size() == 0) begin
            report_mismatch($sformatf("unexpected result tdata=%h tuser=%b", m_tdata, m_tuser));
            return;
        end
        want = pending_frames.pop_front();
        frames_checked++;
        if (m_tdata[7:0] !== want.key)
            report_mismatch($sformatf("key %h, want %h", m_tdata[7:0], want.key));
        if (m_tuser !== want.code_ok)
            report_mismatch($sformatf("code_ok %b, want %b", m_tuser, want.code_ok));
        if (m_tdata[15:8] !== want.addr_lo)
            report_mismatch($sformatf("address_low %h, want %h", m_tdata[15:8], want.addr_lo));
        if (m_tdata[23:16] !== want.addr_hi)
            report_mismatch($sformatf("address_high %h, want %h", m_tdata[23:16],
                                      want.addr_hi));
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) check_frame_result();
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                     quiet_cycles, pending_frames.size());
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles = quiet_cycles + 1;
        end
    end

    initial begin : result_sink
        int hold;
        forever begin
            hold = stall_enable ? $urandom_range(0, 6) : 0;
            if (hold != 0) begin
                m_tready <= 1'b0;
                do @(posedge aclk); while (!m_tvalid);
                repeat (hold - 1) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    task automatic send_edge(input logic [7:0] ticks, input logic tmo);
        int gap;
        gap = gap_enable ? $urandom_range(0, 6) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ticks;
        s_tuser  <= tmo;
        do @(posedge aclk); while (!s_tready);
        advance_receiver(ticks, tmo);
        edges_sent++;
    endtask

    task automatic send_bits(input logic [31:0] bits, input int count, input int miss_pct);
        logic [7:0] ticks;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 99) < miss_pct)
                ticks = 8'($urandom_range(0, int'(model_cfg.repeat_limit)));
            else if (bits[k])
                ticks = pick_ticks(model_cfg.one_min, model_cfg.one_max);
            else
                ticks = pick_ticks(model_cfg.zero_min, model_cfg.zero_max);
            send_edge(ticks, 1'b0);
        end
    endtask

    task automatic send_frame(input logic [7:0] start, input logic [31:0] bits,
                              input int miss_pct);
        send_edge(start, 1'b0);
        send_bits(bits, 32, miss_pct);
    endtask

    task automatic drain_decoder();
        s_tvalid <= 1'b0;
        while (pending_frames.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_ZERO_MIN:     model_cfg.zero_min     = value;
            REG_ZERO_MAX:     model_cfg.zero_max     = value;
            REG_ONE_MIN:      model_cfg.one_min      = value;
            REG_ONE_MAX:      model_cfg.one_max      = value;
            REG_LEAD_LIMIT:   model_cfg.lead_limit   = value;
            REG_REPEAT_LIMIT: model_cfg.repeat_limit = value;
            default: ;
        endcase
        regs_written++;
    endtask

    task automatic load_windows(input cfg_t c);
        drain_decoder();
        write_reg(REG_ZERO_MIN, c.zero_min);
        write_reg(REG_ZERO_MAX, c.zero_max);
        write_reg(REG_ONE_MIN, c.one_min);
        write_reg(REG_ONE_MAX, c.one_max);
        write_reg(REG_LEAD_LIMIT, c.lead_limit);
        write_reg(REG_REPEAT_LIMIT, c.repeat_limit);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_boundary_edges();
        gap_enable   = 1'b0;
        stall_enable = 1'b0;
        send_edge(8'h00, 1'b0);
        send_edge(8'hff, 1'b1);
        send_edge(8'h55, 1'b1);
        send_edge(8'haa, 1'b0);
        send_edge(8'h55, 1'b0);
        send_edge(8'h00, 1'b1);
        send_edge(RST_REPEAT_LIMIT, 1'b0);
        send_edge(RST_REPEAT_LIMIT + 8'd1, 1'b0);
        send_edge(RST_LEAD_LIMIT, 1'b0);
        send_edge(RST_LEAD_LIMIT + 8'd1, 1'b0);
        send_edge(8'hff, 1'b0);
        send_edge(8'h01, 1'b0);
        send_edge(8'h00, 1'b1);
    endtask

    task automatic test_clean_frames();
        for (int f = 0; f < 6; f++) begin
            gap_enable   = (f >= 2);
            stall_enable = (f >= 3);
            send_edge(8'($urandom), 1'b1);
            send_frame(lead_ticks(), random_payload(1'b1), 0);
        end
    endtask

    task automatic test_repeat_and_restart();
        gap_enable   = 1'b1;
        stall_enable = 1'b1;
        // repeat flag keeps storing after a finished frame
        send_edge(8'h00, 1'b1);
        send_frame(lead_ticks(), random_payload(1'b1), 0);
        send_bits(random_payload(1'b1), 32, 0);
        send_edge(8'h00, 1'b1);
        send_frame(repeat_ticks(), random_payload(1'b1), 0);
        // lead code in mid frame restarts it
        send_edge(8'h00, 1'b1);
        send_edge(lead_ticks(), 1'b0);
        send_bits(random_payload(1'b1), 15, 0);
        send_frame(lead_ticks(), random_payload(1'b1), 0);
        // last interval of a frame opens the next one
        send_edge(8'h00, 1'b1);
        send_edge(lead_ticks(), 1'b0);
        send_bits(random_payload(1'b1), 31, 0);
        send_frame(lead_ticks(), random_payload(1'b1), 0);
        // timeout in mid frame drops it
        send_edge(8'h00, 1'b1);
        send_edge(lead_ticks(), 1'b0);
        send_bits(random_payload(1'b1), 10, 0);
        send_edge(8'h00, 1'b1);
        send_bits(random_payload(1'b1), 32, 0);
        send_edge(8'h00, 1'b1);
        send_frame(lead_ticks(), random_payload(1'b1), 30);
        send_edge(8'h00, 1'b1);
        send_frame(lead_ticks(), random_payload(1'b0), 0);
    endtask

    task automatic test_register_sweep();
        cfg_t plan [7];
        plan[0] = make_windows(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        plan[1] = make_windows(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
        plan[2] = make_windows(8'h00, 8'hff, 8'h00, 8'hff, 8'hff, 8'hfe);
        plan[3] = make_windows(8'd9, 8'd11, 8'd19, 8'd21, 8'd200, 8'd150);
        plan[4] = make_windows(8'd10, 8'd40, 8'd30, 8'd60, 8'd250, 8'd100);
        plan[5] = random_windows();
        plan[6] = make_windows(RST_ZERO_MIN, RST_ZERO_MAX, RST_ONE_MIN, RST_ONE_MAX,
                               RST_LEAD_LIMIT, RST_REPEAT_LIMIT);
        foreach (plan[p]) begin
            load_windows(plan[p]);
            gap_enable   = p[0];
            stall_enable = !p[0];
            send_edge(8'($urandom), 1'b1);
            send_frame($urandom_range(0, 1) ? lead_ticks() : repeat_ticks(),
                       random_payload(1'b1), 10);
            send_edge(8'h00, 1'b1);
            send_edge(lead_ticks(), 1'b0);
            repeat (32) send_edge(8'h00, 1'b0);
        end
    endtask

    task automatic test_random_traffic();
        int first_frame;
        int since_cfg;
        first_frame = frames_predicted;
        since_cfg   = 0;
        while (edges_sent < ITEM_TARGET || frames_predicted - first_frame < RANDOM_FRAMES) begin
            gap_enable   = $urandom_range(0, 3) != 0;
            stall_enable = $urandom_range(0, 3) != 0;
            if (since_cfg >= 8) begin
                load_windows(random_windows());
                since_cfg = 0;
            end
            case ($urandom_range(0, 9))
                0: begin
                    repeat ($urandom_range(1, 8))
                        send_edge(8'($urandom), $urandom_range(0, 4) == 0);
                end
                1: begin
                    send_edge(lead_ticks(), 1'b0);
                    send_bits(random_payload(1'b1), $urandom_range(1, 31), 5);
                    send_edge(8'($urandom), 1'b1);
                end
                default: begin
                    if ($urandom_range(0, 2) != 0) send_edge(8'($urandom), 1'b1);
                    send_frame($urandom_range(0, 3) == 0 ? repeat_ticks() : lead_ticks(),
                               random_payload($urandom_range(0, 7) != 0),
                               $urandom_range(0, 3) == 0 ? 5 : 0);
                    since_cfg++;
                end
            endcase
        end
    endtask

    initial begin
        clear_receiver();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_boundary_edges();
        test_clean_frames();
        test_repeat_and_restart();
        test_register_sweep();
        test_random_traffic();
        drain_decoder();
        $display("sent %0d IR edges over default, extreme and random windows (%0d reg writes)",
                 edges_sent, regs_written);
        $display("checked %0d decoded frames, %0d mismatches", frames_checked, mismatches);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
